>>> rtl/cko_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and a helper function for the commutator operator entry block.
// Depends on nothing; imported by the top level of the block.
package cko_pkg;

    // Store geometry.
    localparam int MAX_MATRIX_DIM = 8;
    localparam int MAX_GAMMA_DIM  = 4;
    localparam int MAX_PAIRS      = 4;

    localparam int MD_W = $clog2(MAX_MATRIX_DIM);
    localparam int GD_W = $clog2(MAX_GAMMA_DIM);
    localparam int PR_W = $clog2(MAX_PAIRS);

    localparam int GS_DEPTH = MAX_PAIRS * MAX_GAMMA_DIM * MAX_GAMMA_DIM;
    localparam int MS_DEPTH = MAX_PAIRS * MAX_MATRIX_DIM * MAX_MATRIX_DIM;
    localparam int GS_AW    = $clog2(GS_DEPTH);
    localparam int MS_AW    = $clog2(MS_DEPTH);

    // Number formats.
    localparam int GAMMA_W = 16;
    localparam int X_W     = 24;
    localparam int D_W     = X_W + 1;
    localparam int PROD_W  = GAMMA_W + D_W;
    localparam int ACC_W   = 50;
    localparam int OUT_W   = 48;

    // Operation codes of an input word.
    localparam logic [1:0] OP_LOAD_GAMMA  = 2'd0;
    localparam logic [1:0] OP_LOAD_MATRIX = 2'd1;
    localparam logic [1:0] OP_QUERY       = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_MATRIX_DIM   = 2'd0;
    localparam logic [1:0] REG_GAMMA_DIM    = 2'd1;
    localparam logic [1:0] REG_MATRIX_COUNT = 2'd2;

    // Quotient of an 8-bit value by a small divisor from 1 to 8. Divisors 3, 5, 6
    // and 7 use a scaled reciprocal that is exact over the whole 8-bit range.
    function automatic logic [7:0] div_small(input logic [7:0] x, input logic [3:0] d);
        logic [18:0] by3;
        logic [18:0] by5;
        logic [18:0] by7;
        logic [7:0]  q;
        by3 = 19'(x) * 19'd171;
        by5 = 19'(x) * 19'd205;
        by7 = 19'(x) * 19'd293;
        case (d)
            4'd1:    q = x;
            4'd2:    q = {1'b0, x[7:1]};
            4'd3:    q = by3[16:9];
            4'd4:    q = {2'b0, x[7:2]};
            4'd5:    q = by5[17:10];
            4'd6:    q = {1'b0, by3[16:10]};
            4'd7:    q = by7[18:11];
            4'd8:    q = {3'b0, x[7:3]};
            default: q = x;
        endcase
        return q;
    endfunction

endpackage

>>> rtl/cko_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cko_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds while rd_en is low.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/commutator_kron_operator_entry.sv
`timescale 1ns / 1ps
// Top level of the commutator operator entry block: stores, decode and shared multiplier.
// Depends on cko_pkg and cko_ram.
//
// Usage: input words arrive on in_valid/in_ready. A gamma or matrix load is
// written into its store in the cycle it is accepted and gives no result; the
// block stays ready. A query decodes its row and column in the states DEC1 and
// DEC2, then walks the matrix pairs with one shared 16x25 multiplier: per pair
// two store reads (RDA, RDB), a difference step (DIF) and four products (M0 to
// M3). The walk covers P pairs (P = capped matrix_count); after it, FIN lets
// the last product drain. RES loads the output word; a query out of range, or
// with P zero, skips to it. One query is in work at a time.
// Results leave through an output register on out_valid/out_ready; a new word
// is accepted while an earlier result waits, and a finished query holds in its
// last state until the output register is free.
// Reset clears the sequencer and output valid and sets N=8, G=4, P=4. The
// stores are not cleared; entries read by a query must have been loaded.
// Configuration writes on cfg_write take effect at once and belong to idle time.
module commutator_kron_operator_entry
    import cko_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [3:0]              cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              operation,
    input  logic [1:0]              which_pair,
    input  logic [2:0]              elem_row,
    input  logic [2:0]              elem_col,
    input  logic signed [23:0]      value_re,
    input  logic signed [23:0]      value_im,
    input  logic [7:0]              query_row,
    input  logic [7:0]              query_col,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [47:0]      entry_re,
    output logic signed [47:0]      entry_im,
    output logic                    saturated,
    output logic                    out_of_range
);

    // Sequencer state codes.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DEC1 = 4'd1;
    localparam logic [3:0] ST_DEC2 = 4'd2;
    localparam logic [3:0] ST_RDA  = 4'd3;
    localparam logic [3:0] ST_RDB  = 4'd4;
    localparam logic [3:0] ST_DIF  = 4'd5;
    localparam logic [3:0] ST_M0   = 4'd6;
    localparam logic [3:0] ST_M1   = 4'd7;
    localparam logic [3:0] ST_M2   = 4'd8;
    localparam logic [3:0] ST_M3   = 4'd9;
    localparam logic [3:0] ST_FIN  = 4'd10;
    localparam logic [3:0] ST_RES  = 4'd11;

    // Accumulate operation codes for the product register.
    localparam logic [1:0] ACC_ADD_RE = 2'd0;
    localparam logic [1:0] ACC_SUB_RE = 2'd1;
    localparam logic [1:0] ACC_ADD_IM = 2'd2;

    logic [3:0]              state_reg;
    logic [3:0]              state_next;
    logic [3:0]              matrix_dim_reg;
    logic [2:0]              gamma_dim_reg;
    logic [2:0]              matrix_count_reg;
    logic [7:0]              qr_reg;
    logic [7:0]              qc_reg;
    logic                    oor_reg;
    logic [7:0]              rrow_reg;
    logic [7:0]              rcol_reg;
    logic [GD_W-1:0]         m_reg;
    logic [GD_W-1:0]         n_reg;
    logic [MD_W-1:0]         i_reg;
    logic [MD_W-1:0]         j_reg;
    logic [MD_W-1:0]         k_reg;
    logic [MD_W-1:0]         l_reg;
    logic [PR_W-1:0]         p_reg;
    logic signed [X_W-1:0]   xa_re_reg;
    logic signed [X_W-1:0]   xa_im_reg;
    logic signed [D_W-1:0]   d_re_reg;
    logic signed [D_W-1:0]   d_im_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [1:0]              acc_op_reg;
    logic                    acc_pend_reg;
    logic signed [ACC_W-1:0] acc_re_reg;
    logic signed [ACC_W-1:0] acc_im_reg;
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] entry_re_reg;
    logic signed [OUT_W-1:0] entry_im_reg;
    logic                    saturated_reg;
    logic                    out_of_range_reg;

    logic                    in_accept;
    logic                    out_free;
    logic [3:0]              n_cap;
    logic [2:0]              g_cap;
    logic [2:0]              p_cap;
    logic [10:0]             op_size;
    logic                    query_oor;
    logic                    last_pair;

    logic                    g_wr_en;
    logic [GS_AW-1:0]        g_wr_addr;
    logic [2*GAMMA_W-1:0]    g_wr_data;
    logic                    g_rd_en;
    logic [GS_AW-1:0]        g_rd_addr;
    logic [2*GAMMA_W-1:0]    g_rd_data;
    logic                    m_wr_en;
    logic [MS_AW-1:0]        m_wr_addr;
    logic [2*X_W-1:0]        m_wr_data;
    logic                    m_rd_en;
    logic [MS_AW-1:0]        m_rd_addr;
    logic [2*X_W-1:0]        m_rd_data;

    logic signed [GAMMA_W-1:0] g_re;
    logic signed [GAMMA_W-1:0] g_im;
    logic signed [X_W-1:0]   xb_re;
    logic signed [X_W-1:0]   xb_im;
    logic signed [D_W-1:0]   term_a_re;
    logic signed [D_W-1:0]   term_a_im;
    logic signed [D_W-1:0]   term_b_re;
    logic signed [D_W-1:0]   term_b_im;
    logic signed [GAMMA_W-1:0] mul_a;
    logic signed [D_W-1:0]   mul_b;
    logic signed [ACC_W-1:0] acc_term;

    logic [7:0]              rrow_q;
    logic [7:0]              rcol_q;
    logic [10:0]             rrow_mul;
    logic [10:0]             rcol_mul;
    logic [7:0]              m_rem;
    logic [7:0]              n_rem;
    logic [7:0]              i_q;
    logic [7:0]              k_q;
    logic [11:0]             i_mul;
    logic [11:0]             k_mul;
    logic [7:0]              j_rem;
    logic [7:0]              l_rem;

    logic                    sat_re;
    logic                    sat_im;
    logic signed [OUT_W-1:0] clamp_re;
    logic signed [OUT_W-1:0] clamp_im;

    // Handshake and capped dimensions.
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign n_cap = (matrix_dim_reg > 4'(MAX_MATRIX_DIM)) ? 4'(MAX_MATRIX_DIM) : matrix_dim_reg;
    assign g_cap = (gamma_dim_reg > 3'(MAX_GAMMA_DIM)) ? 3'(MAX_GAMMA_DIM) : gamma_dim_reg;
    assign p_cap = (matrix_count_reg > 3'(MAX_PAIRS)) ? 3'(MAX_PAIRS) : matrix_count_reg;
    assign op_size   = 11'(g_cap) * 11'(n_cap) * 11'(n_cap);
    assign query_oor = (11'(query_row) >= op_size) || (11'(query_col) >= op_size);
    assign last_pair = (({1'b0, p_reg} + 3'd1) == p_cap);

    // Store write ports, driven straight from an accepted load word.
    assign g_wr_en   = in_accept && (operation == OP_LOAD_GAMMA)
                       && ({1'b0, which_pair} < 3'(MAX_PAIRS))
                       && ({1'b0, elem_row} < 4'(MAX_GAMMA_DIM))
                       && ({1'b0, elem_col} < 4'(MAX_GAMMA_DIM));
    assign g_wr_addr = {which_pair[PR_W-1:0], elem_row[GD_W-1:0], elem_col[GD_W-1:0]};
    assign g_wr_data = {value_re[GAMMA_W-1:0], value_im[GAMMA_W-1:0]};

    assign m_wr_en   = in_accept && (operation == OP_LOAD_MATRIX)
                       && ({1'b0, which_pair} < 3'(MAX_PAIRS))
                       && ({1'b0, elem_row} < 4'(MAX_MATRIX_DIM))
                       && ({1'b0, elem_col} < 4'(MAX_MATRIX_DIM));
    assign m_wr_addr = {which_pair[PR_W-1:0], elem_row[MD_W-1:0], elem_col[MD_W-1:0]};
    assign m_wr_data = {value_re, value_im};

    // Store read ports: gamma and X[k][i] in one cycle, X[j][l] in the next.
    assign g_rd_en   = (state_reg == ST_RDA);
    assign g_rd_addr = {p_reg, m_reg, n_reg};
    assign m_rd_en   = state_reg inside {ST_RDA, ST_RDB};
    assign m_rd_addr = (state_reg == ST_RDA) ? {p_reg, k_reg, i_reg} : {p_reg, j_reg, l_reg};

    cko_ram #(
        .WIDTH (2 * GAMMA_W),
        .DEPTH (GS_DEPTH)
    ) u_gamma_ram (
        .clk     (clk),
        .wr_en   (g_wr_en),
        .wr_addr (g_wr_addr),
        .wr_data (g_wr_data),
        .rd_en   (g_rd_en),
        .rd_addr (g_rd_addr),
        .rd_data (g_rd_data)
    );

    cko_ram #(
        .WIDTH (2 * X_W),
        .DEPTH (MS_DEPTH)
    ) u_matrix_ram (
        .clk     (clk),
        .wr_en   (m_wr_en),
        .wr_addr (m_wr_addr),
        .wr_data (m_wr_data),
        .rd_en   (m_rd_en),
        .rd_addr (m_rd_addr),
        .rd_data (m_rd_data)
    );

    // Index decode: first split off the gamma index, then the matrix indexes.
    assign rrow_q   = div_small(qr_reg, {1'b0, g_cap});
    assign rcol_q   = div_small(qc_reg, {1'b0, g_cap});
    assign rrow_mul = 11'(rrow_q) * 11'(g_cap);
    assign rcol_mul = 11'(rcol_q) * 11'(g_cap);
    assign m_rem    = qr_reg - rrow_mul[7:0];
    assign n_rem    = qc_reg - rcol_mul[7:0];

    assign i_q      = div_small(rrow_reg, n_cap);
    assign k_q      = div_small(rcol_reg, n_cap);
    assign i_mul    = 12'(i_q) * 12'(n_cap);
    assign k_mul    = 12'(k_q) * 12'(n_cap);
    assign j_rem    = rrow_reg - i_mul[7:0];
    assign l_rem    = rcol_reg - k_mul[7:0];

    // Commutator difference, each term masked by its Kronecker delta.
    assign g_re  = g_rd_data[2*GAMMA_W-1:GAMMA_W];
    assign g_im  = g_rd_data[GAMMA_W-1:0];
    assign xb_re = m_rd_data[2*X_W-1:X_W];
    assign xb_im = m_rd_data[X_W-1:0];

    assign term_a_re = (j_reg == l_reg) ? D_W'(xa_re_reg) : '0;
    assign term_a_im = (j_reg == l_reg) ? D_W'(xa_im_reg) : '0;
    assign term_b_re = (i_reg == k_reg) ? D_W'(xb_re) : '0;
    assign term_b_im = (i_reg == k_reg) ? D_W'(xb_im) : '0;

    // Shared multiplier: four real products per pair, one per cycle.
    always_comb
    begin
        case (state_reg)
            ST_M0:
            begin
                mul_a = g_re;
                mul_b = d_re_reg;
            end
            ST_M1:
            begin
                mul_a = g_im;
                mul_b = d_im_reg;
            end
            ST_M2:
            begin
                mul_a = g_im;
                mul_b = d_re_reg;
            end
            default:
            begin
                mul_a = g_re;
                mul_b = d_im_reg;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign acc_term  = ACC_W'(prod_reg);

    // Saturation of the accumulated sums to the output width.
    assign sat_re   = !((&acc_re_reg[ACC_W-1:OUT_W-1]) || !(|acc_re_reg[ACC_W-1:OUT_W-1]));
    assign sat_im   = !((&acc_im_reg[ACC_W-1:OUT_W-1]) || !(|acc_im_reg[ACC_W-1:OUT_W-1]));
    assign clamp_re = sat_re ? (acc_re_reg[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                                    : {1'b0, {(OUT_W-1){1'b1}}})
                             : acc_re_reg[OUT_W-1:0];
    assign clamp_im = sat_im ? (acc_im_reg[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                                    : {1'b0, {(OUT_W-1){1'b1}}})
                             : acc_im_reg[OUT_W-1:0];

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (operation == OP_QUERY))
                begin
                    state_next = query_oor ? ST_RES : ST_DEC1;
                end
            end
            ST_DEC1: state_next = ST_DEC2;
            ST_DEC2: state_next = (p_cap == 3'd0) ? ST_RES : ST_RDA;
            ST_RDA:  state_next = ST_RDB;
            ST_RDB:  state_next = ST_DIF;
            ST_DIF:  state_next = ST_M0;
            ST_M0:   state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = last_pair ? ST_FIN : ST_RDA;
            ST_FIN:  state_next = ST_RES;
            ST_RES:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            matrix_dim_reg   <= 4'd8;
            gamma_dim_reg    <= 3'd4;
            matrix_count_reg <= 3'd4;
            p_reg            <= '0;
            acc_pend_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MATRIX_DIM:   matrix_dim_reg   <= cfg_data;
                    REG_GAMMA_DIM:    gamma_dim_reg    <= cfg_data[2:0];
                    REG_MATRIX_COUNT: matrix_count_reg <= cfg_data[2:0];
                    default:          ;
                endcase
            end

            if (in_accept)
            begin
                p_reg <= '0;
            end
            else if ((state_reg == ST_M3) && !last_pair)
            begin
                p_reg <= p_reg + 1'b1;
            end

            acc_pend_reg <= state_reg inside {ST_M0, ST_M1, ST_M2, ST_M3};

            if ((state_reg == ST_RES) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            qr_reg  <= query_row;
            qc_reg  <= query_col;
            oor_reg <= query_oor;
        end

        if (state_reg == ST_DEC1)
        begin
            rrow_reg <= rrow_q;
            rcol_reg <= rcol_q;
            m_reg    <= m_rem[GD_W-1:0];
            n_reg    <= n_rem[GD_W-1:0];
        end

        if (state_reg == ST_DEC2)
        begin
            i_reg <= i_q[MD_W-1:0];
            j_reg <= j_rem[MD_W-1:0];
            k_reg <= k_q[MD_W-1:0];
            l_reg <= l_rem[MD_W-1:0];
        end

        if (state_reg == ST_RDB)
        begin
            xa_re_reg <= xb_re;
            xa_im_reg <= xb_im;
        end

        if (state_reg == ST_DIF)
        begin
            d_re_reg <= term_a_re - term_b_re;
            d_im_reg <= term_a_im - term_b_im;
        end

        // Product register and the operation that consumes it next cycle.
        prod_reg <= prod_next;
        case (state_reg)
            ST_M0:   acc_op_reg <= ACC_ADD_RE;
            ST_M1:   acc_op_reg <= ACC_SUB_RE;
            default: acc_op_reg <= ACC_ADD_IM;
        endcase

        // Accumulators, cleared when a word is taken.
        if (in_accept)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (acc_pend_reg)
        begin
            case (acc_op_reg)
                ACC_ADD_RE: acc_re_reg <= acc_re_reg + acc_term;
                ACC_SUB_RE: acc_re_reg <= acc_re_reg - acc_term;
                default:    acc_im_reg <= acc_im_reg + acc_term;
            endcase
        end

        // Output word register.
        if ((state_reg == ST_RES) && out_free)
        begin
            entry_re_reg     <= clamp_re;
            entry_im_reg     <= clamp_im;
            saturated_reg    <= sat_re || sat_im;
            out_of_range_reg <= oor_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign entry_re     = entry_re_reg;
    assign entry_im     = entry_im_reg;
    assign saturated    = saturated_reg;
    assign out_of_range = out_of_range_reg;

    // A new result word appears only out of the result state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_RES))
        else $error("result word without a finished query");

    // An out-of-range word carries a zero entry and no saturation.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (entry_re == '0 && entry_im == '0 && !saturated))
        else $error("out-of-range word with nonzero entry");

    // The pair counter stays below the capped pair count while pairs are walked.
    a_pair_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg >= ST_RDA && state_reg <= ST_M3) |-> ({1'b0, p_reg} < p_cap))
        else $error("pair counter beyond pair count");

    // Every product has been accumulated before the result is formed.
    a_acc_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RES) |-> !acc_pend_reg)
        else $error("product still pending at result");

endmodule
